// ===== rtl/sfs_pkg.sv =====
// ============================================================================
// sfs_pkg: shared types and constants of the full-step stepper sequencer
// Holds the default widths, register reset value, direction and mode codes,
// the coil pattern table and the status bundle passed from the step core.
// ============================================================================
package sfs_pkg;

   localparam int POSITION_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF    = 16;

   localparam int               RUN_STEPS_BITS  = 16;
   localparam logic [15:0]      RUN_STEPS_RESET = 16'd512;

   localparam int COIL_BITS  = 4;
   localparam int PHASE_BITS = 2;

   localparam logic [PHASE_BITS-1:0] PHASE_FIRST = 2'd0;
   localparam logic [PHASE_BITS-1:0] PHASE_LAST  = 2'd3;

   // Direction codes.
   localparam logic DIR_CW  = 1'b0;
   localparam logic DIR_CCW = 1'b1;

   // Blink interval codes.
   localparam logic ANGLE_FINE   = 1'b0;
   localparam logic ANGLE_COARSE = 1'b1;

   // Button presses carried by one transaction.
   typedef struct packed {
      logic start_stop;
      logic dir;
      logic angle;
      logic home;
   } press_type;

   // Single-bit status of one result.
   typedef struct packed {
      logic busy;
      logic dir_led;
      logic run_led;
      logic mode_led;
      logic blink;
   } status_type;

   // Clockwise two-phase-on full-step sequence, one pattern per phase.
   function automatic logic [COIL_BITS-1:0] cw_pattern(input logic [PHASE_BITS-1:0] ph);
      logic [COIL_BITS-1:0] pat;
      case (ph)
         2'd0:    pat = 4'b0011;
         2'd1:    pat = 4'b0110;
         2'd2:    pat = 4'b1100;
         2'd3:    pat = 4'b1001;
         default: pat = 4'b0011;
      endcase
      return pat;
   endfunction

endpackage

// ===== rtl/sfs_step_core.sv =====
// ============================================================================
// sfs_step_core: sequencer state and per-tick update
// Holds all sequencer state and applies one phase tick whenever the top level
// advances a transaction; the state registers double as the result register.
// ============================================================================
module sfs_step_core #(
   parameter int POSITION_BITS = sfs_pkg::POSITION_BITS_DEF,
   parameter int COUNT_BITS    = sfs_pkg::COUNT_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   fire_i,
   input  sfs_pkg::press_type                     press_i,
   input  logic [sfs_pkg::RUN_STEPS_BITS-1:0]     run_steps_i,
   output logic [sfs_pkg::COIL_BITS-1:0]          coil_o,
   output logic signed [POSITION_BITS-1:0]        position_o,
   output sfs_pkg::status_type                    status_o
);

   localparam int SW_A = (POSITION_BITS > sfs_pkg::RUN_STEPS_BITS) ?
                         POSITION_BITS : sfs_pkg::RUN_STEPS_BITS;
   localparam int SW   = (SW_A > COUNT_BITS) ? SW_A : COUNT_BITS;

   localparam logic [SW-1:0] CNT_MAX_W = SW'({COUNT_BITS{1'b1}});
   localparam logic signed [POSITION_BITS-1:0] POS_MAX =
      {1'b0, {(POSITION_BITS-1){1'b1}}};
   localparam logic signed [POSITION_BITS-1:0] NEG_MAX =
      {1'b1, {(POSITION_BITS-2){1'b0}}, 1'b1};

   logic signed [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                            active_ff, active_in;
   logic                            homing_ff, homing_in;
   logic                            dir_ff, dir_in;
   logic                            angle_ff, angle_in;
   logic [COUNT_BITS-1:0]           done_ff, done_in;
   logic [COUNT_BITS-1:0]           total_ff, total_in;
   logic [sfs_pkg::PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [sfs_pkg::COIL_BITS-1:0]   coil_ff, coil_in;
   logic                            dir_led_ff, dir_led_in;
   logic                            run_led_ff, run_led_in;
   logic                            mode_led_ff, mode_led_in;
   logic                            blink_ff, blink_in;

   logic [POSITION_BITS-1:0] pos_u, pos_neg, pos_mag;
   logic [SW-1:0]            run_w, mag_w, run_sat_w, mag_sat_w;
   logic [COUNT_BITS-1:0]    run_total, mag_total;
   logic [COUNT_BITS:0]      done_inc;
   logic                     dir_new, angle_new, drive;

   // Run lengths saturate to the step counter range.
   always_comb begin
      pos_u     = pos_ff;
      pos_neg   = ~pos_u + POSITION_BITS'(1);
      pos_mag   = pos_ff[POSITION_BITS-1] ? pos_neg : pos_u;
      run_w     = SW'(run_steps_i);
      mag_w     = SW'(pos_mag);
      run_sat_w = (run_w > CNT_MAX_W) ? CNT_MAX_W : run_w;
      mag_sat_w = (mag_w > CNT_MAX_W) ? CNT_MAX_W : mag_w;
      run_total = run_sat_w[COUNT_BITS-1:0];
      mag_total = mag_sat_w[COUNT_BITS-1:0];
      done_inc  = {1'b0, done_ff} + (COUNT_BITS+1)'(1);
   end

   always_comb begin
      pos_in      = pos_ff;
      active_in   = active_ff;
      homing_in   = homing_ff;
      dir_in      = dir_ff;
      angle_in    = angle_ff;
      done_in     = done_ff;
      total_in    = total_ff;
      phase_in    = phase_ff;
      coil_in     = coil_ff;
      dir_led_in  = dir_led_ff;
      run_led_in  = run_led_ff;
      mode_led_in = mode_led_ff;
      blink_in    = 1'b0;
      dir_new     = dir_ff;
      angle_new   = angle_ff;
      drive       = 1'b0;

      if (!active_ff) begin
         if (press_i.start_stop) begin
            active_in   = 1'b1;
            homing_in   = 1'b0;
            dir_in      = sfs_pkg::DIR_CW;
            angle_in    = sfs_pkg::ANGLE_FINE;
            dir_led_in  = 1'b1;
            run_led_in  = 1'b1;
            mode_led_in = 1'b1;
            total_in    = run_total;
            done_in     = '0;
            phase_in    = sfs_pkg::PHASE_FIRST;
            // A zero-length run ends on the tick that arms it.
            if (run_total == '0) begin
               active_in  = 1'b0;
               run_led_in = 1'b0;
            end
         end else if (press_i.home && pos_ff != '0) begin
            dir_in    = pos_ff[POSITION_BITS-1] ? sfs_pkg::DIR_CW : sfs_pkg::DIR_CCW;
            angle_in  = sfs_pkg::ANGLE_FINE;
            homing_in = 1'b1;
            active_in = 1'b1;
            total_in  = mag_total;
            done_in   = '0;
            phase_in  = sfs_pkg::PHASE_FIRST;
         end
      end else begin
         drive = 1'b1;
         if (phase_ff == sfs_pkg::PHASE_FIRST) begin
            if (press_i.start_stop) begin
               drive      = 1'b0;
               active_in  = 1'b0;
               run_led_in = 1'b0;
               homing_in  = 1'b0;
               phase_in   = sfs_pkg::PHASE_FIRST;
               if (homing_ff) begin
                  pos_in = '0;
               end
            end else begin
               if (press_i.dir) begin
                  dir_new    = ~dir_ff;
                  dir_led_in = (dir_new == sfs_pkg::DIR_CW);
               end
               if (press_i.angle) begin
                  angle_new   = ~angle_ff;
                  mode_led_in = (angle_new == sfs_pkg::ANGLE_FINE);
               end
            end
         end
         dir_in   = dir_new;
         angle_in = angle_new;

         if (drive) begin
            coil_in = (dir_new == sfs_pkg::DIR_CW) ? sfs_pkg::cw_pattern(phase_ff)
                                                   : sfs_pkg::cw_pattern(~phase_ff);
            if (phase_ff == sfs_pkg::PHASE_LAST) begin
               if (dir_new == sfs_pkg::DIR_CW) begin
                  if (pos_ff < POS_MAX) begin
                     pos_in = pos_ff + POSITION_BITS'(1);
                  end
               end else begin
                  if (pos_ff > NEG_MAX) begin
                     pos_in = pos_ff - POSITION_BITS'(1);
                  end
               end
               blink_in = (angle_new == sfs_pkg::ANGLE_FINE) ? (done_ff[3:0] == 4'd0)
                                                             : (done_ff[5:0] == 6'd0);
               done_in  = done_inc[COUNT_BITS-1:0];
               phase_in = sfs_pkg::PHASE_FIRST;
               if (done_inc >= {1'b0, total_ff}) begin
                  active_in  = 1'b0;
                  run_led_in = 1'b0;
                  homing_in  = 1'b0;
                  if (homing_ff) begin
                     pos_in = '0;
                  end
               end
            end else begin
               phase_in = phase_ff + sfs_pkg::PHASE_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         active_ff   <= 1'b0;
         homing_ff   <= 1'b0;
         dir_ff      <= sfs_pkg::DIR_CW;
         angle_ff    <= sfs_pkg::ANGLE_FINE;
         done_ff     <= '0;
         total_ff    <= '0;
         phase_ff    <= sfs_pkg::PHASE_FIRST;
         coil_ff     <= '0;
         dir_led_ff  <= 1'b0;
         run_led_ff  <= 1'b0;
         mode_led_ff <= 1'b0;
         blink_ff    <= 1'b0;
      end else if (fire_i) begin
         pos_ff      <= pos_in;
         active_ff   <= active_in;
         homing_ff   <= homing_in;
         dir_ff      <= dir_in;
         angle_ff    <= angle_in;
         done_ff     <= done_in;
         total_ff    <= total_in;
         phase_ff    <= phase_in;
         coil_ff     <= coil_in;
         dir_led_ff  <= dir_led_in;
         run_led_ff  <= run_led_in;
         mode_led_ff <= mode_led_in;
         blink_ff    <= blink_in;
      end
   end

   assign coil_o            = coil_ff;
   assign position_o        = pos_ff;
   assign status_o.busy     = active_ff;
   assign status_o.dir_led  = dir_led_ff;
   assign status_o.run_led  = run_led_ff;
   assign status_o.mode_led = mode_led_ff;
   assign status_o.blink    = blink_ff;

`ifndef SYNTHESIS
   a_run_led_needs_active: assert property (@(posedge clock) disable iff (reset)
      run_led_ff |-> (active_ff && !homing_ff))
      else $error("run LED lit without an active started run");

   a_phase_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != sfs_pkg::PHASE_FIRST) |-> active_ff)
      else $error("mid-step phase while idle");

   a_done_below_total: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (done_ff < total_ff))
      else $error("active run has already reached its step count");

   a_hold_without_fire: assert property (@(posedge clock) disable iff (reset)
      !fire_i |=> ($stable(pos_ff) && $stable(coil_ff) && $stable(blink_ff)))
      else $error("result changed without a tick");
`endif

endmodule

// ===== rtl/stepper_full_step_sequencer.sv =====
// ============================================================================
// stepper_full_step_sequencer: full-step sequencer for a unipolar stepper
// Input register, single-pass step core and result handshake for one phase
// tick per transaction, plus the run length configuration register.
// ============================================================================
// An accepted tick waits in the input register, and the step core writes its result
// into the state/result registers whenever the result stage is free.
// Throughput: one transaction per cycle while rsp_stall is low; the step core
// updates all state in a single pass between input and state/result registers.
// Reset (synchronous, active high) clears all sequencer state, empties both
// stages and loads run_steps with 512; the block accepts input right away.
module stepper_full_step_sequencer #(
   parameter int POSITION_BITS = sfs_pkg::POSITION_BITS_DEF,
   parameter int COUNT_BITS    = sfs_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration port for run_steps.
   input  logic                                csr_wr_en,
   input  logic [sfs_pkg::RUN_STEPS_BITS-1:0]  csr_wr_data,
   // Input channel: one phase tick per transaction.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_start_stop_press,
   input  logic                                req_dir_press,
   input  logic                                req_angle_press,
   input  logic                                req_home_press,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sfs_pkg::COIL_BITS-1:0]       rsp_coil_drive,
   output logic signed [POSITION_BITS-1:0]     rsp_position,
   output logic                                rsp_busy_res,
   output logic                                rsp_dir_led,
   output logic                                rsp_run_led,
   output logic                                rsp_mode_led,
   output logic                                rsp_blink
);

   logic [sfs_pkg::RUN_STEPS_BITS-1:0] run_steps_ff;
   logic                               req_valid_ff, req_valid_in;
   sfs_pkg::press_type                 press_ff, press_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               out_free;
   logic                               fire;
   sfs_pkg::status_type                status;

   // The result stage can take a new result when it is empty or when its
   // current transaction completes in this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // A held tick advances into the step core whenever the result stage is free.
   assign fire      = req_valid_ff && out_free;

   // The input register only stalls while it holds a tick that cannot advance,
   // so a new transaction can be taken in every cycle of a free-flowing stream.
   assign req_stall = req_valid_ff && !out_free;

   always_comb begin
      press_in.start_stop = req_start_stop_press;
      press_in.dir        = req_dir_press;
      press_in.angle      = req_angle_press;
      press_in.home       = req_home_press;
      req_valid_in        = req_stall ? req_valid_ff : req_valid;
      rsp_valid_in        = fire ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         run_steps_ff <= sfs_pkg::RUN_STEPS_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            run_steps_ff <= csr_wr_data;
         end
      end
   end

   // The press payload is captured with each accepted transaction.
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         press_ff <= press_in;
      end
   end

   // The step core holds the sequencer state; its registers update only on a
   // tick, so they also serve as the result register and hold while stalled.
   sfs_step_core #(
      .POSITION_BITS (POSITION_BITS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire_i      (fire),
      .press_i     (press_ff),
      .run_steps_i (run_steps_ff),
      .coil_o      (rsp_coil_drive),
      .position_o  (rsp_position),
      .status_o    (status)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_busy_res = status.busy;
   assign rsp_dir_led  = status.dir_led;
   assign rsp_run_led  = status.run_led;
   assign rsp_mode_led = status.mode_led;
   assign rsp_blink    = status.blink;

endmodule

// ===== test/stepper_full_step_sequencer_checker.sv =====
// ============================================================================
// stepper_full_step_sequencer_checker: result predictor and comparator
// Watches the configuration port and both channels of the sequencer. It runs
// its own model of the motor state for each accepted transaction and compares
// every accepted result with the oldest predicted one.
// ============================================================================
module stepper_full_step_sequencer_checker #(
   parameter int POSITION_BITS = sfs_pkg::POSITION_BITS_DEF,
   parameter int COUNT_BITS    = sfs_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sfs_pkg::RUN_STEPS_BITS-1:0]  csr_wr_data,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_start_stop_press,
   input  logic                                req_dir_press,
   input  logic                                req_angle_press,
   input  logic                                req_home_press,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [sfs_pkg::COIL_BITS-1:0]       rsp_coil_drive,
   input  logic signed [POSITION_BITS-1:0]     rsp_position,
   input  logic                                rsp_busy_res,
   input  logic                                rsp_dir_led,
   input  logic                                rsp_run_led,
   input  logic                                rsp_mode_led,
   input  logic                                rsp_blink,
   output int unsigned                         mismatch_count,
   output int unsigned                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint POS_MAX   = (longint'(1) << (POSITION_BITS - 1)) - 1;
   localparam longint COUNT_MAX = (longint'(1) << COUNT_BITS) - 1;

   localparam logic [sfs_pkg::COIL_BITS-1:0] WAVE [4] =
      '{4'b0011, 4'b0110, 4'b1100, 4'b1001};

   typedef struct {
      logic [sfs_pkg::COIL_BITS-1:0] coil;
      longint                        position;
      logic                          busy;
      logic                          dir_led;
      logic                          run_led;
      logic                          mode_led;
      logic                          blink;
   } motor_tick_type;

   motor_tick_type expected_ticks[$];

   logic [sfs_pkg::RUN_STEPS_BITS-1:0] run_length;
   longint                             shaft_pos;
   logic                               moving;
   logic                               homing_run;
   logic                               spin_dir;
   logic                               blink_mode;
   longint                             steps_taken;
   longint                             steps_goal;
   logic [sfs_pkg::PHASE_BITS-1:0]     phase;
   logic [sfs_pkg::COIL_BITS-1:0]      coil_out;
   logic                               led_dir;
   logic                               led_run;
   logic                               led_mode;

   function automatic longint clamp_count(input longint v);
      return (v > COUNT_MAX) ? COUNT_MAX : v;
   endfunction

   function automatic void halt_motor();
      moving  = 1'b0;
      led_run = 1'b0;
      if (homing_run) begin
         shaft_pos = 0;
      end
      homing_run = 1'b0;
      phase      = sfs_pkg::PHASE_FIRST;
   endfunction

   function automatic motor_tick_type advance_motor(input logic ss, input logic dp,
                                                    input logic ap, input logic hp);
      motor_tick_type                 r;
      logic                           drive;
      logic [sfs_pkg::PHASE_BITS-1:0] mirror;
      r.blink = 1'b0;
      drive   = 1'b1;
      if (!moving) begin
         if (ss) begin
            moving     = 1'b1;
            homing_run = 1'b0;
            spin_dir   = sfs_pkg::DIR_CW;
            blink_mode = sfs_pkg::ANGLE_FINE;
            led_dir    = 1'b1;
            led_run    = 1'b1;
            led_mode   = 1'b1;
            steps_goal  = clamp_count(longint'(run_length));
            steps_taken = 0;
            phase       = sfs_pkg::PHASE_FIRST;
            if (steps_goal == 0) begin
               halt_motor();
            end
         end else if (hp && shaft_pos != 0) begin
            if (shaft_pos > 0) begin
               spin_dir   = sfs_pkg::DIR_CCW;
               steps_goal = clamp_count(shaft_pos);
            end else begin
               spin_dir   = sfs_pkg::DIR_CW;
               steps_goal = clamp_count(-shaft_pos);
            end
            blink_mode  = sfs_pkg::ANGLE_FINE;
            homing_run  = 1'b1;
            moving      = 1'b1;
            steps_taken = 0;
            phase       = sfs_pkg::PHASE_FIRST;
         end
      end else begin
         // Presses only count on the first phase of a step.
         if (phase == sfs_pkg::PHASE_FIRST) begin
            if (ss) begin
               halt_motor();
               drive = 1'b0;
            end else begin
               if (dp) begin
                  spin_dir = ~spin_dir;
                  led_dir  = (spin_dir == sfs_pkg::DIR_CW);
               end
               if (ap) begin
                  blink_mode = ~blink_mode;
                  led_mode   = (blink_mode == sfs_pkg::ANGLE_FINE);
               end
            end
         end
         if (drive) begin
            mirror   = sfs_pkg::PHASE_LAST - phase;
            coil_out = (spin_dir == sfs_pkg::DIR_CW) ? WAVE[phase] : WAVE[mirror];
            if (phase == sfs_pkg::PHASE_LAST) begin
               if (spin_dir == sfs_pkg::DIR_CW) begin
                  if (shaft_pos < POS_MAX) shaft_pos++;
               end else begin
                  if (shaft_pos > -POS_MAX) shaft_pos--;
               end
               if (blink_mode == sfs_pkg::ANGLE_FINE) begin
                  r.blink = (steps_taken % 16) == 0;
               end else begin
                  r.blink = (steps_taken % 64) == 0;
               end
               steps_taken++;
               if (steps_taken >= steps_goal) begin
                  halt_motor();
               end else begin
                  phase = sfs_pkg::PHASE_FIRST;
               end
            end else begin
               phase = phase + sfs_pkg::PHASE_BITS'(1);
            end
         end
      end
      r.coil     = coil_out;
      r.position = shaft_pos;
      r.busy     = moving;
      r.dir_led  = led_dir;
      r.run_led  = led_run;
      r.mode_led = led_mode;
      return r;
   endfunction

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      motor_tick_type want;
      if (reset) begin
         mismatch_count = 0;
         run_length  = sfs_pkg::RUN_STEPS_RESET;
         shaft_pos   = 0;
         moving      = 1'b0;
         homing_run  = 1'b0;
         spin_dir    = sfs_pkg::DIR_CW;
         blink_mode  = sfs_pkg::ANGLE_FINE;
         steps_taken = 0;
         steps_goal  = 0;
         phase       = sfs_pkg::PHASE_FIRST;
         coil_out    = '0;
         led_dir     = 1'b0;
         led_run     = 1'b0;
         led_mode    = 1'b0;
         expected_ticks.delete();
      end else begin
         if (csr_wr_en) begin
            run_length = csr_wr_data;
         end
         // A result leaves the block only after passing the input register and the
         // step core registers, so its prediction is always queued by then.
         if (rsp_valid && !rsp_stall) begin
            if (expected_ticks.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: result with none expected, expected none, actual coil %0d",
                        $time, rsp_coil_drive);
            end else begin
               want = expected_ticks.pop_front();
               check_field("coil_drive", longint'(want.coil), longint'(rsp_coil_drive));
               check_field("position", want.position, longint'(rsp_position));
               check_field("busy_res", longint'(want.busy), longint'(rsp_busy_res));
               check_field("dir_led", longint'(want.dir_led), longint'(rsp_dir_led));
               check_field("run_led", longint'(want.run_led), longint'(rsp_run_led));
               check_field("mode_led", longint'(want.mode_led), longint'(rsp_mode_led));
               check_field("blink", longint'(want.blink), longint'(rsp_blink));
            end
         end
         if (req_valid && !req_stall) begin
            expected_ticks.push_back(advance_motor(req_start_stop_press, req_dir_press,
                                                   req_angle_press, req_home_press));
         end
      end
      pending_count <= $unsigned(expected_ticks.size());
   end

endmodule

// ===== test/stepper_full_step_sequencer_tb.sv =====
// ============================================================================
// stepper_full_step_sequencer_tb: top level testbench of the step sequencer
// Drives phase ticks with button presses into the sequencer, applies random
// gaps and result back-pressure, changes the run length between phases and
// reports the verdict from the failure count of the checker.
// ============================================================================
module stepper_full_step_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Steps of each flat-out run, enough that a home run of 20 ticks stops early.
   localparam int FLAT_STEPS = 8;
   // Long receiver hold-off that fills the block and stalls its input.
   localparam int HOLD_OFF_CYCLES = 100;
   // Cycles waited at the end after every predicted result has come back.
   localparam int DRAIN_CYCLES = 8;

   logic                                        clock = 1'b0;
   logic                                        reset = 1'b1;
   logic                                        csr_wr_en = 1'b0;
   logic [sfs_pkg::RUN_STEPS_BITS-1:0]          csr_wr_data = '0;
   logic                                        req_valid = 1'b0;
   logic                                        req_stall;
   logic                                        req_start_stop_press = 1'b0;
   logic                                        req_dir_press = 1'b0;
   logic                                        req_angle_press = 1'b0;
   logic                                        req_home_press = 1'b0;
   logic                                        rsp_valid;
   logic                                        rsp_stall = 1'b0;
   logic [sfs_pkg::COIL_BITS-1:0]               rsp_coil_drive;
   logic signed [sfs_pkg::POSITION_BITS_DEF-1:0] rsp_position;
   logic                                        rsp_busy_res;
   logic                                        rsp_dir_led;
   logic                                        rsp_run_led;
   logic                                        rsp_mode_led;
   logic                                        rsp_blink;

   int unsigned mismatch_count;
   int unsigned pending_count;

   // When cleared, both sides run flat out: no sender gaps, no receiver stalls.
   bit gaps_on = 1'b1;
   // Counts the long hold-offs that the stimulus has asked the receiver for.
   int unsigned hold_off_asked = 0;

   stepper_full_step_sequencer u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_start_stop_press (req_start_stop_press),
      .req_dir_press        (req_dir_press),
      .req_angle_press      (req_angle_press),
      .req_home_press       (req_home_press),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_coil_drive       (rsp_coil_drive),
      .rsp_position         (rsp_position),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_dir_led          (rsp_dir_led),
      .rsp_run_led          (rsp_run_led),
      .rsp_mode_led         (rsp_mode_led),
      .rsp_blink            (rsp_blink)
   );

   stepper_full_step_sequencer_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_start_stop_press (req_start_stop_press),
      .req_dir_press        (req_dir_press),
      .req_angle_press      (req_angle_press),
      .req_home_press       (req_home_press),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_coil_drive       (rsp_coil_drive),
      .rsp_position         (rsp_position),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_dir_led          (rsp_dir_led),
      .rsp_run_led          (rsp_run_led),
      .rsp_mode_led         (rsp_mode_led),
      .rsp_blink            (rsp_blink),
      .mismatch_count       (mismatch_count),
      .pending_count        (pending_count)
   );

   // A 10 ns clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Idle lengths in cycles: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (!gaps_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Offers one phase tick and returns at the edge where it is accepted.
   // Valid is only lowered when a gap follows, so back-to-back transactions
   // keep it high without a lower and raise in the same time step.
   task automatic send_tick(input logic ss, input logic dp, input logic ap, input logic hp);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_start_stop_press <= ss;
      req_dir_press        <= dp;
      req_angle_press      <= ap;
      req_home_press       <= hp;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering and waits until every predicted result has come back.
   // The count from the checker is registered, hence the first wait.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // The run length register is only written while nothing is in flight.
   task automatic write_run_steps(input logic [sfs_pkg::RUN_STEPS_BITS-1:0] steps);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= steps;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One stretch of random ticks at a given run length. Start and stop presses
   // are kept rarer than the others so that runs get a chance to finish.
   task automatic random_phase(input logic [sfs_pkg::RUN_STEPS_BITS-1:0] steps,
                               input int count, input int stop_pct,
                               input bit with_hold_off);
      write_run_steps(steps);
      if (with_hold_off) begin
         hold_off_asked++;
      end
      repeat (count) begin
         send_tick($urandom_range(0, 99) < stop_pct, $urandom_range(0, 99) < 15,
                   $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 15);
      end
   endtask

   // Receiver: random stall runs, an occasional long hold-off on request,
   // and no stalls at all while the gaps are switched off.
   initial begin : receiver
      int          stall_left;
      int          free_left;
      int unsigned hold_off_done;
      stall_left    = 0;
      free_left     = 0;
      hold_off_done = 0;
      forever begin
         @(posedge clock);
         if (hold_off_asked != hold_off_done) begin
            hold_off_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            stall_left = 0;
            free_left  = 1;
         end
         if (!gaps_on) begin
            rsp_stall <= 1'b0;
            stall_left = 0;
            free_left  = 0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (free_left > 0) begin
            rsp_stall <= 1'b0;
            free_left--;
         end else begin
            stall_left = pick_gap();
            free_left  = $urandom_range(1, 8);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed ticks at the reset run length of 512. An idle motor ignores
      // the toggles, and a home press at position zero does nothing.
      send_tick(1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b1, 1'b1, 1'b0);
      // A start press wins over a home press on the same tick; this only arms.
      send_tick(1'b1, 1'b0, 1'b0, 1'b1);
      // Both toggles land on the first step boundary together.
      send_tick(1'b0, 1'b1, 1'b1, 1'b0);
      // Every press in the middle of a step is ignored.
      send_tick(1'b1, 1'b1, 1'b1, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0, 1'b0);
      // Last phase: position goes to -1 and step zero blinks.
      send_tick(1'b0, 1'b0, 1'b0, 1'b0);
      // Stop on the boundary: no phase is driven and the run LED goes out.
      send_tick(1'b1, 1'b0, 1'b0, 1'b0);
      // Home from -1 runs clockwise for one step and ends at zero.
      send_tick(1'b0, 1'b0, 1'b0, 1'b1);
      repeat (4) send_tick(1'b0, 1'b0, 1'b0, 1'b0);

      // A zero run length ends the run on its arm tick.
      write_run_steps('0);
      send_tick(1'b1, 1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0, 1'b0);

      // One-step run, then a home run stopped on its first boundary, which
      // still clears the position.
      write_run_steps(sfs_pkg::RUN_STEPS_BITS'(1));
      send_tick(1'b1, 1'b0, 1'b0, 1'b0);
      repeat (4) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0, 1'b1);
      send_tick(1'b1, 1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0, 1'b0);

      // Longest run length, stopped by hand after a few steps each way.
      // These stretches run flat out with back-to-back transactions.
      write_run_steps('1);
      gaps_on = 1'b0;
      send_tick(1'b1, 1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b1, 1'b0, 1'b0);
      repeat (4 * FLAT_STEPS - 1) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0, 1'b0, 1'b0);
      // Home clockwise from the negative position, stopped early.
      send_tick(1'b0, 1'b0, 1'b0, 1'b1);
      repeat (20) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0, 1'b0, 1'b0);
      // Clockwise in coarse blink mode.
      send_tick(1'b1, 1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1, 1'b0);
      repeat (4 * FLAT_STEPS - 1) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0, 1'b0, 1'b0);
      // Home counter-clockwise from the positive position, stopped early.
      send_tick(1'b0, 1'b0, 1'b0, 1'b1);
      repeat (12) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0, 1'b0, 1'b0);
      gaps_on = 1'b1;

      // Random phases. Each one starts after the sender has paused until all
      // results are back. Two of them also carry a long receiver hold-off
      // while the sender keeps offering transactions.
      random_phase(sfs_pkg::RUN_STEPS_BITS'(3), 120, 8, 1'b0);
      random_phase(sfs_pkg::RUN_STEPS_BITS'(1), 80, 10, 1'b0);
      random_phase(sfs_pkg::RUN_STEPS_BITS'(70), 220, 1, 1'b1);
      random_phase(sfs_pkg::RUN_STEPS_BITS'(12), 150, 5, 1'b0);
      random_phase(sfs_pkg::RUN_STEPS_BITS'($urandom_range(2, 30)), 100, 5, 1'b1);
      random_phase('1, 60, 10, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: a correct run ends well before this.
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
